@@ sv/plist_pkg.sv @@
// ----------------------------------------------------------------------------
// plist_pkg: shared constants and types for the positional list engine
// Sizes, command and status codes, and the control and result bundles that
// pass between the storage cells, the group selectors and the top level.
// ----------------------------------------------------------------------------
package plist_pkg;

    // List capacity and the widths that follow from it
    localparam int CAPACITY = 128;
    localparam int IW       = $clog2(CAPACITY);       // cell index
    localparam int CW       = $clog2(CAPACITY + 1);   // entry count
    localparam int CMPW     = ((CW > 8) ? CW : 8) + 1; // position compares

    // Cells are resolved in groups of eight, then across groups
    localparam int GRP      = 8;
    localparam int GW       = 3;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int GIW      = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int FW       = GIW + GW;               // flat padded index
    localparam int NPAD     = NGRP * GRP;

    typedef logic [31:0] word_t;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Broadcast control to every cell
    typedef struct packed {
        logic          ins;   // shift up from p, load val at p
        logic          del;   // shift down from p
        logic          srch;  // hit on value match instead of index match
        logic [IW-1:0] p;     // zero-based position
        word_t         val;
        logic [CW-1:0] cnt;
    } cell_ctl_t;

    // First hit within one group of cells
    typedef struct packed {
        logic          any;
        logic [GW-1:0] sub;
        word_t         data;
    } grp_res_t;

endpackage

@@ sv/positional_list_insert_delete_search.sv @@
// Positional list engine: a chain of CAPACITY word cells with group selectors.
// Steps: latch command, per-group first-hit select, final select plus cell
// shift, with the result word registered at the final step. done arrives in
// the cycle where busy falls; no new command is taken while busy is high.
// Results cannot be stalled.
// Reset empties the list at once.
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search: ordered list with insert, delete,
// search and read by 1-based position, one result word per command.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search
    import plist_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         cmd,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               done,
    output logic [2:0]         status,
    output logic signed [31:0] data_out,
    output logic [7:0]         found_position,
    output logic [7:0]         entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_FINAL
    } state_t;

    state_t        state_reg, state_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;

    logic [2:0]    cmd_reg;
    logic [7:0]    pos_reg;
    word_t         val_reg;
    status_t       status_reg, status_next;
    word_t         data_reg, data_next;
    logic [7:0]    found_reg, found_next;
    logic [7:0]    ecount_reg, ecount_next;
    grp_res_t      grp_reg [NGRP];

    logic              accept;
    logic [CMPW-1:0]   pos_ext, pos_m1, cnt_ext;
    logic              pos_ok_ins, pos_ok_rd, ins_ok, del_ok;
    cell_ctl_t         ctl;
    logic [NPAD-1:0]   cell_hit;
    logic [NPAD-1:0][31:0] cell_data;
    grp_res_t          grp_res [NGRP];
    logic              sel_any;
    logic [FW-1:0]     sel_idx;
    word_t             sel_data;
    logic [FW:0]       sel_pos;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Position checks against the current count
    assign pos_ext    = CMPW'(pos_reg);
    assign cnt_ext    = CMPW'(count_reg);
    assign pos_m1     = pos_ext - CMPW'(1);
    assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign pos_ok_rd  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign ins_ok     = (cmd_reg == CMD_INSERT) && (cnt_ext < CMPW'(CAPACITY))
                        && pos_ok_ins;
    assign del_ok     = (cmd_reg == CMD_DELETE) && (count_reg != '0) && pos_ok_rd;

    // Broadcast control; shifts happen only on the final edge
    always_comb
    begin
        ctl.ins  = (state_reg == S_FINAL) && ins_ok;
        ctl.del  = (state_reg == S_FINAL) && del_ok;
        ctl.srch = (cmd_reg == CMD_SEARCH);
        ctl.p    = pos_m1[IW-1:0];
        ctl.val  = val_reg;
        ctl.cnt  = count_reg;
    end

    // Cell chain
    for (genvar i = 0; i < NPAD; i++)
    begin : g_cell
        if (i < CAPACITY)
        begin : g_real
            word_t left_w, right_w, data_w;
            logic  hit_w;
            if (i == 0)
            begin : g_first
                assign left_w = cell_data[i];
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[i - 1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[i + 1];
            end
            plist_cell u_cell (
                .clk   (clk),
                .idx   (IW'(i)),
                .ctl   (ctl),
                .left  (left_w),
                .right (right_w),
                .data  (data_w),
                .hit   (hit_w)
            );
            assign cell_data[i] = data_w;
            assign cell_hit[i]  = hit_w;
        end
        else
        begin : g_pad
            assign cell_data[i] = '0;
            assign cell_hit[i]  = 1'b0;
        end
    end

    // Per-group first-hit selectors
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        plist_group u_group (
            .hit  (cell_hit[g * GRP +: GRP]),
            .data (cell_data[g * GRP +: GRP]),
            .res  (grp_res[g])
        );
    end

    // Select the first group with a hit
    always_comb
    begin
        sel_any  = 1'b0;
        sel_idx  = '0;
        sel_data = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_reg[g].any)
            begin
                sel_any  = 1'b1;
                sel_idx  = {GIW'(g), grp_reg[g].sub};
                sel_data = grp_reg[g].data;
            end
        end
        sel_pos = {1'b0, sel_idx} + (FW + 1)'(1);
    end

    // Result and count for the command
    always_comb
    begin
        status_next = ST_OK;
        data_next   = '0;
        found_next  = '0;
        count_next  = count_reg;
        case (cmd_reg)
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_INSERT:
            begin
                if (cnt_ext >= CMPW'(CAPACITY))
                    status_next = ST_OVERFLOW;
                else if (!pos_ok_ins)
                    status_next = ST_BADPOS;
                else
                    count_next = count_reg + CW'(1);
            end
            CMD_DELETE:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (!pos_ok_rd)
                    status_next = ST_BADPOS;
                else
                begin
                    data_next  = sel_data;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_SEARCH:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (sel_any)
                    found_next = 8'(sel_pos);
                else
                    status_next = ST_NOTFOUND;
            end
            CMD_READ:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (!pos_ok_rd)
                    status_next = ST_BADPOS;
                else
                    data_next = sel_data;
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
        ecount_next = 8'(count_next);
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_GROUP;
            end
            S_GROUP:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, strobe and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_FINAL)
                count_reg <= count_next;
        end
    end

    // Latch the command word, group results and the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            val_reg <= value;
        end
        if (state_reg == S_GROUP)
        begin
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_res[g];
        end
        if (state_reg == S_FINAL)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            found_reg  <= found_next;
            ecount_reg <= ecount_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign data_out       = data_reg;
    assign found_position = found_reg;
    assign entry_count    = ecount_reg;

    // Checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy ##1 busy ##1 (done && !busy))
        else $error("command did not complete in three cycles");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (found_position == 8'd0))
        else $error("found position set on a failed command");

    a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_FINAL))
        else $error("done strobe outside final step");

endmodule

@@ sv/plist_cell.sv @@
// ----------------------------------------------------------------------------
// plist_cell: one list entry
// Holds one word, loads the new value or its left or right neighbor on insert or delete,
// and flags a hit for a position or value lookup.
// ----------------------------------------------------------------------------
module plist_cell
    import plist_pkg::*;
(
    input  logic          clk,
    input  logic [IW-1:0] idx,
    input  cell_ctl_t     ctl,
    input  word_t         left,
    input  word_t         right,
    output word_t         data,
    output logic          hit
);

    word_t data_reg;
    word_t data_next;

    // Pick the next entry value
    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (idx == ctl.p)
                data_next = ctl.val;
            else if (idx > ctl.p)
                data_next = left;
        end
        else if (ctl.del)
        begin
            if (idx >= ctl.p)
                data_next = right;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Flag a value match inside the list, or the addressed position
    always_comb
    begin
        if (ctl.srch)
            hit = (data_reg == ctl.val) && ({{(CW - IW){1'b0}}, idx} < ctl.cnt);
        else
            hit = (idx == ctl.p);
    end

    assign data = data_reg;

endmodule

@@ sv/plist_group.sv @@
// ----------------------------------------------------------------------------
// plist_group: first-hit selector for one group of cells
// Finds the lowest cell with a hit and passes its offset and word.
// ----------------------------------------------------------------------------
module plist_group
    import plist_pkg::*;
(
    input  logic [GRP-1:0]            hit,
    input  logic [GRP-1:0][31:0]      data,
    output grp_res_t                  res
);

    // Scan from the top so the lowest hit wins
    always_comb
    begin
        res.any  = 1'b0;
        res.sub  = '0;
        res.data = '0;
        for (int k = GRP - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                res.any  = 1'b1;
                res.sub  = GW'(k);
                res.data = data[k];
            end
        end
    end

endmodule
